### rtl/fsa_pkg.sv
package fsa_pkg;

    localparam int NUM_REGS = 8;
    localparam int RF_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW       = 32;
    localparam int IDX_W    = 3;
    localparam int MODE_W   = 4;

    localparam logic [MODE_W-1:0] MODE_MOV = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 4'd2;
    localparam logic [MODE_W-1:0] MODE_AND = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ORR = 4'd4;
    localparam logic [MODE_W-1:0] MODE_EOR = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LSL = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LSR = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ASR = 4'd8;

    localparam logic [DW-1:0] SIGN_LIMIT = 32'h7fff_ffff;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [DW-1:0] value;
        t_flags        flags;
        logic          wr;
    } t_alu_res;

    function automatic logic rf_hit(logic [IDX_W-1:0] idx);
        return int'(idx) < NUM_REGS;
    endfunction

    function automatic logic [RF_AW-1:0] rf_addr(logic [IDX_W-1:0] idx);
        return RF_AW'(idx);
    endfunction

endpackage

### rtl/flag_setting_alu_with_register_file_unit.sv
// two stages: an accepted request goes through the stage one registers, then the output register
// throughput: one request per cycle unless stalled; register read, alu and write back overlap
// the register file is a synchronous memory with a registered read; a same-cycle write is forwarded
// reset (synchronous, active low) empties the pipeline, zeroes the flags and marks all registers
// unwritten, so they read as zero; no clearing pass is needed
module flag_setting_alu_with_register_file_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [fsa_pkg::MODE_W-1:0] i_mode,
    input  logic [fsa_pkg::IDX_W-1:0]  i_dest_reg,
    input  logic [fsa_pkg::IDX_W-1:0]  i_first_source,
    input  logic [fsa_pkg::IDX_W-1:0]  i_second_source,
    input  logic [fsa_pkg::DW-1:0]     i_immediate_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fsa_pkg::DW-1:0]     o_result_value,
    output logic                       o_flag_negative,
    output logic                       o_flag_zero,
    output logic                       o_flag_carry,
    output logic                       o_flag_overflow
);
    import fsa_pkg::*;

    logic              r_s1_vld;
    logic [MODE_W-1:0] r_s1_mode;
    logic [IDX_W-1:0]  r_s1_rd;
    logic [DW-1:0]     r_s1_imm;
    t_flags            r_flags;
    logic              r_out_vld;
    logic [DW-1:0]     r_out_value;
    t_flags            r_out_flags;

    logic              adv;
    logic              fire;
    logic              accept;
    logic [DW-1:0]     op_a;
    logic [DW-1:0]     op_b;
    t_alu_res          res;

    assign adv        = !r_out_vld || !i_out_stall;
    assign fire       = r_s1_vld && adv;
    assign o_in_stall = r_s1_vld && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    fsa_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_ra    (i_first_source),
        .i_rb    (i_second_source),
        .o_da    (op_a),
        .o_db    (op_b),
        .i_wr_en (fire && res.wr),
        .i_wa    (r_s1_rd),
        .i_wd    (res.value)
    );

    fsa_alu u_alu (
        .i_mode  (r_s1_mode),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_imm   (r_s1_imm),
        .i_flags (r_flags),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (fire) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (fire && res.wr) begin
                r_flags <= res.flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= i_mode;
            r_s1_rd   <= i_dest_reg;
            r_s1_imm  <= i_immediate_value;
        end
        if (fire) begin
            r_out_value <= res.value;
            r_out_flags <= res.flags;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_result_value  = r_out_value;
    assign o_flag_negative = r_out_flags.n;
    assign o_flag_zero     = r_out_flags.z;
    assign o_flag_carry    = r_out_flags.c;
    assign o_flag_overflow = r_out_flags.v;

endmodule

### rtl/fsa_regfile.sv
module fsa_regfile (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [fsa_pkg::IDX_W-1:0] i_ra,
    input  logic [fsa_pkg::IDX_W-1:0] i_rb,
    output logic [fsa_pkg::DW-1:0]    o_da,
    output logic [fsa_pkg::DW-1:0]    o_db,
    input  logic                   i_wr_en,
    input  logic [fsa_pkg::IDX_W-1:0] i_wa,
    input  logic [fsa_pkg::DW-1:0]    i_wd
);
    import fsa_pkg::*;

    logic [DW-1:0]       r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [DW-1:0]       r_da;
    logic [DW-1:0]       r_db;
    logic                r_va;
    logic                r_vb;
    logic                wr_ok;
    logic                fwd_a;
    logic                fwd_b;

    assign wr_ok = i_wr_en && rf_hit(i_wa);
    assign fwd_a = wr_ok && (i_wa == i_ra);
    assign fwd_b = wr_ok && (i_wa == i_rb);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[rf_addr(i_wa)] <= i_wd;
        end
        if (i_rd_en) begin
            r_da <= fwd_a ? i_wd : r_mem[rf_addr(i_ra)];
            r_db <= fwd_b ? i_wd : r_mem[rf_addr(i_rb)];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_valid[rf_addr(i_wa)] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va <= rf_hit(i_ra) && (fwd_a || r_valid[rf_addr(i_ra)]);
                r_vb <= rf_hit(i_rb) && (fwd_b || r_valid[rf_addr(i_rb)]);
            end
        end
    end

    assign o_da = r_va ? r_da : '0;
    assign o_db = r_vb ? r_db : '0;

endmodule

### rtl/fsa_alu.sv
module fsa_alu (
    input  logic [fsa_pkg::MODE_W-1:0] i_mode,
    input  logic [fsa_pkg::DW-1:0]     i_a,
    input  logic [fsa_pkg::DW-1:0]     i_b,
    input  logic [fsa_pkg::DW-1:0]     i_imm,
    input  fsa_pkg::t_flags            i_flags,
    output fsa_pkg::t_alu_res          o_res
);
    import fsa_pkg::*;

    logic [DW:0]   sum;
    logic [DW:0]   dif;
    logic [DW:0]   lsl_w;
    logic [DW:0]   lsr_w;
    logic [DW:0]   asr_w;
    logic [7:0]    amt;
    logic [5:0]    sh;
    logic          amt_zero;
    logic          amt_big;
    logic [DW-1:0] r;
    t_flags        f;
    logic          setnz;
    logic          wr;

    assign amt      = i_b[7:0];
    assign amt_zero = (amt == 8'd0);
    assign amt_big  = (amt > 8'd32);
    assign sh       = amt_big ? 6'd32 : amt[5:0];

    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign dif   = {1'b0, i_a} + {1'b0, ~i_b} + {{DW{1'b0}}, 1'b1};
    assign lsl_w = {1'b0, i_a} << sh;
    assign lsr_w = {i_a, 1'b0} >> sh;
    assign asr_w = $unsigned($signed({i_a, 1'b0}) >>> sh);

    always_comb begin
        r     = '0;
        f     = i_flags;
        setnz = 1'b1;
        wr    = 1'b1;
        case (i_mode)
            MODE_MOV: begin
                r     = i_imm;
                setnz = 1'b0;
            end
            MODE_ADD: begin
                r   = sum[DW-1:0];
                f.c = sum[DW];
                f.v = i_a[DW-1] ~^ i_b[DW-1] && (r[DW-1] != i_a[DW-1]);
            end
            MODE_SUB: begin
                r   = dif[DW-1:0];
                f.c = dif[DW];
                f.v = (i_a[DW-1] ^ i_b[DW-1]) && (r[DW-1] != i_a[DW-1]);
            end
            MODE_AND: r = i_a & i_b;
            MODE_ORR: r = i_a | i_b;
            MODE_EOR: r = i_a ^ i_b;
            MODE_LSL: begin
                if (amt_zero) begin
                    r = i_a;
                end else if (amt_big) begin
                    r   = '0;
                    f.c = 1'b0;
                end else begin
                    r   = lsl_w[DW-1:0];
                    f.c = lsl_w[DW];
                end
            end
            MODE_LSR: begin
                if (amt_zero) begin
                    r = i_a;
                end else if (amt_big) begin
                    r   = '0;
                    f.c = 1'b0;
                end else begin
                    r   = lsr_w[DW:1];
                    f.c = lsr_w[0];
                end
            end
            MODE_ASR: begin
                if (amt_zero) begin
                    r = i_a;
                end else begin
                    r   = asr_w[DW:1];
                    f.c = asr_w[0];
                end
            end
            default: begin
                setnz = 1'b0;
                wr    = 1'b0;
            end
        endcase
        if (setnz) begin
            f.n = r > SIGN_LIMIT;
            f.z = (r == '0);
        end
    end

    assign o_res.value = r;
    assign o_res.flags = f;
    assign o_res.wr    = wr;

endmodule

### rtl/fsa_checker.sv
module fsa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [fsa_pkg::DW-1:0]     o_result_value,
    input logic                       o_flag_negative,
    input logic                       o_flag_zero,
    input logic                       o_flag_carry,
    input logic                       o_flag_overflow
);
    import fsa_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_flag_negative) && $stable(o_flag_zero)
            && $stable(o_flag_carry) && $stable(o_flag_overflow))
        else $error("stalled result changed");

    // empty output never backs up the input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // every accepted request reaches the output through stage one and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("request lost");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind flag_setting_alu_with_register_file_unit fsa_checker u_fsa_checker (.*);

### tb/flag_setting_alu_with_register_file_unit_tb.sv
`timescale 1ns / 1ps

module flag_setting_alu_with_register_file_unit_tb;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [fsa_pkg::MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
    localparam logic [fsa_pkg::MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    typedef struct {
        logic [fsa_pkg::DW-1:0] value;
        fsa_pkg::t_flags        flags;
    } t_exp_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [fsa_pkg::MODE_W-1:0] i_mode = '0;
    logic [fsa_pkg::IDX_W-1:0]  i_dest_reg = '0;
    logic [fsa_pkg::IDX_W-1:0]  i_first_source = '0;
    logic [fsa_pkg::IDX_W-1:0]  i_second_source = '0;
    logic [fsa_pkg::DW-1:0]     i_immediate_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [fsa_pkg::DW-1:0]     o_result_value;
    logic                       o_flag_negative;
    logic                       o_flag_zero;
    logic                       o_flag_carry;
    logic                       o_flag_overflow;

    logic [fsa_pkg::DW-1:0] model_regs [fsa_pkg::NUM_REGS];
    fsa_pkg::t_flags        model_flags;
    t_exp_result            expected_results [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_cycles = 0;
    int error_count = 0;
    int cycle_count = 0;

    flag_setting_alu_with_register_file_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_dest_reg        (i_dest_reg),
        .i_first_source    (i_first_source),
        .i_second_source   (i_second_source),
        .i_immediate_value (i_immediate_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_value    (o_result_value),
        .o_flag_negative   (o_flag_negative),
        .o_flag_zero       (o_flag_zero),
        .o_flag_carry      (o_flag_carry),
        .o_flag_overflow   (o_flag_overflow)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("flag_setting_alu_with_register_file_unit: mismatch");
            $finish;
        end
    end

    function automatic t_exp_result predict_alu(
        input logic [fsa_pkg::MODE_W-1:0] mode,
        input logic [fsa_pkg::IDX_W-1:0]  rd,
        input logic [fsa_pkg::IDX_W-1:0]  rn,
        input logic [fsa_pkg::IDX_W-1:0]  rm,
        input logic [fsa_pkg::DW-1:0]     imm
    );
        logic [fsa_pkg::DW-1:0] a;
        logic [fsa_pkg::DW-1:0] b;
        logic [fsa_pkg::DW-1:0] r;
        logic [7:0]             amt;
        logic                   carry;
        logic                   executes;
        logic                   set_nz;
        fsa_pkg::t_flags        f;
        t_exp_result            res;
        a = (int'(rn) < fsa_pkg::NUM_REGS) ? model_regs[rn] : '0;
        b = (int'(rm) < fsa_pkg::NUM_REGS) ? model_regs[rm] : '0;
        amt = b[7:0];
        f = model_flags;
        r = '0;
        executes = 1'b1;
        set_nz = 1'b1;
        case (mode)
            fsa_pkg::MODE_MOV: begin
                r = imm;
                set_nz = 1'b0;
            end
            fsa_pkg::MODE_ADD: begin
                {carry, r} = {1'b0, a} + {1'b0, b};
                f.c = carry;
                f.v = (a[31] ^ r[31]) & (b[31] ^ r[31]);
            end
            fsa_pkg::MODE_SUB: begin
                r = a - b;
                f.c = (a >= b);
                f.v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
            end
            fsa_pkg::MODE_AND: r = a & b;
            fsa_pkg::MODE_ORR: r = a | b;
            fsa_pkg::MODE_EOR: r = a ^ b;
            fsa_pkg::MODE_LSL: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    r = a << amt;
                    f.c = a[32 - int'(amt)];
                end else if (amt == 32) begin
                    r = '0;
                    f.c = a[0];
                end else begin
                    r = '0;
                    f.c = 1'b0;
                end
            end
            fsa_pkg::MODE_LSR: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    r = a >> amt;
                    f.c = a[int'(amt) - 1];
                end else if (amt == 32) begin
                    r = '0;
                    f.c = a[31];
                end else begin
                    r = '0;
                    f.c = 1'b0;
                end
            end
            fsa_pkg::MODE_ASR: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    r = $unsigned($signed(a) >>> amt);
                    f.c = a[int'(amt) - 1];
                end else begin
                    r = {fsa_pkg::DW{a[31]}};
                    f.c = a[31];
                end
            end
            default: begin
                executes = 1'b0;
                set_nz = 1'b0;
            end
        endcase
        if (set_nz) begin
            f.n = r[31];
            f.z = (r == '0);
        end
        if (executes) begin
            if (int'(rd) < fsa_pkg::NUM_REGS) begin
                model_regs[rd] = r;
            end
            model_flags = f;
        end
        res.value = r;
        res.flags = f;
        return res;
    endfunction

    task automatic send_request(
        input logic [fsa_pkg::MODE_W-1:0] mode,
        input logic [fsa_pkg::IDX_W-1:0]  rd,
        input logic [fsa_pkg::IDX_W-1:0]  rn,
        input logic [fsa_pkg::IDX_W-1:0]  rm,
        input logic [fsa_pkg::DW-1:0]     imm
    );
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            i_mode <= fsa_pkg::MODE_W'($urandom);
            i_dest_reg <= fsa_pkg::IDX_W'($urandom);
            i_first_source <= fsa_pkg::IDX_W'($urandom);
            i_second_source <= fsa_pkg::IDX_W'($urandom);
            i_immediate_value <= $urandom;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_dest_reg <= rd;
        i_first_source <= rn;
        i_second_source <= rm;
        i_immediate_value <= imm;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_alu(mode, rd, rn, rm, imm));
    endtask

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_exp_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: value %h", o_result_value);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result_value !== exp_res.value) begin
                    $error("result_value: expected %h, got %h", exp_res.value, o_result_value);
                    error_count++;
                end
                if (o_flag_negative !== exp_res.flags.n) begin
                    $error("flag_negative: expected %b, got %b", exp_res.flags.n,
                           o_flag_negative);
                    error_count++;
                end
                if (o_flag_zero !== exp_res.flags.z) begin
                    $error("flag_zero: expected %b, got %b", exp_res.flags.z, o_flag_zero);
                    error_count++;
                end
                if (o_flag_carry !== exp_res.flags.c) begin
                    $error("flag_carry: expected %b, got %b", exp_res.flags.c, o_flag_carry);
                    error_count++;
                end
                if (o_flag_overflow !== exp_res.flags.v) begin
                    $error("flag_overflow: expected %b, got %b", exp_res.flags.v,
                           o_flag_overflow);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [fsa_pkg::DW-1:0] pick_operand();
        logic [fsa_pkg::DW-1:0] val;
        case ($urandom_range(4))
            0: val = $urandom_range(40);
            1: begin
                case ($urandom_range(5))
                    0: val = 32'h0000_0000;
                    1: val = 32'h0000_0001;
                    2: val = fsa_pkg::SIGN_LIMIT;
                    3: val = 32'h8000_0000;
                    4: val = 32'hffff_fffe;
                    default: val = 32'hffff_ffff;
                endcase
            end
            2: val = $urandom;
            3: val = {24'($urandom_range(32'h00ff_ffff)), 8'($urandom_range(40))};
            default: val = $urandom | 32'h8000_0000;
        endcase
        return val;
    endfunction

    task automatic test_reset_state();
        send_request(fsa_pkg::MODE_ORR, 3'd3, 3'd5, 3'd6, $urandom);
    endtask

    task automatic test_mov_extremes();
        send_request(fsa_pkg::MODE_MOV, 3'd0, 3'd0, 3'd0, 32'hffff_ffff);
        send_request(fsa_pkg::MODE_MOV, 3'd1, 3'd7, 3'd7, fsa_pkg::SIGN_LIMIT);
        send_request(fsa_pkg::MODE_MOV, 3'd2, 3'd0, 3'd0, 32'h8000_0000);
        send_request(fsa_pkg::MODE_MOV, 3'd3, 3'd0, 3'd0, 32'h0000_0001);
    endtask

    task automatic test_add_sub_flags();
        send_request(fsa_pkg::MODE_ADD, 3'd4, 3'd1, 3'd3, '0);
        send_request(fsa_pkg::MODE_ADD, 3'd5, 3'd0, 3'd3, '0);
        send_request(fsa_pkg::MODE_SUB, 3'd6, 3'd3, 3'd3, '0);
        send_request(fsa_pkg::MODE_SUB, 3'd6, 3'd2, 3'd3, '0);
        send_request(fsa_pkg::MODE_SUB, 3'd7, 3'd3, 3'd0, '0);
    endtask

    task automatic test_logical_ops();
        send_request(fsa_pkg::MODE_AND, 3'd7, 3'd0, 3'd2, '0);
        send_request(fsa_pkg::MODE_EOR, 3'd7, 3'd0, 3'd0, '0);
        send_request(fsa_pkg::MODE_ORR, 3'd7, 3'd1, 3'd2, '0);
    endtask

    task automatic test_shift_edges();
        send_request(fsa_pkg::MODE_MOV, 3'd7, 3'd0, 3'd0, 32'd32);
        send_request(fsa_pkg::MODE_LSL, 3'd4, 3'd3, 3'd7, '0);
        send_request(fsa_pkg::MODE_LSR, 3'd4, 3'd2, 3'd7, '0);
        send_request(fsa_pkg::MODE_ASR, 3'd4, 3'd2, 3'd7, '0);
        send_request(fsa_pkg::MODE_MOV, 3'd7, 3'd0, 3'd0, 32'd33);
        send_request(fsa_pkg::MODE_LSL, 3'd4, 3'd0, 3'd7, '0);
        send_request(fsa_pkg::MODE_ASR, 3'd4, 3'd1, 3'd7, '0);
        send_request(fsa_pkg::MODE_MOV, 3'd7, 3'd0, 3'd0, 32'h0000_0100);
        send_request(fsa_pkg::MODE_LSR, 3'd4, 3'd0, 3'd7, '0);
        send_request(fsa_pkg::MODE_MOV, 3'd7, 3'd0, 3'd0, 32'd1);
        send_request(fsa_pkg::MODE_ASR, 3'd4, 3'd2, 3'd7, '0);
        send_request(fsa_pkg::MODE_MOV, 3'd7, 3'd0, 3'd0, 32'd31);
        send_request(fsa_pkg::MODE_LSL, 3'd4, 3'd0, 3'd7, '0);
    endtask

    task automatic test_unused_modes();
        send_request(MODE_UNUSED_LO, 3'd0, 3'd1, 3'd2, 32'hdead_beef);
        send_request(MODE_UNUSED_HI, 3'd1, 3'd0, 3'd0, 32'hffff_ffff);
    endtask

    task automatic test_random(input int count);
        logic [fsa_pkg::MODE_W-1:0] mode;
        logic [fsa_pkg::DW-1:0]     imm;
        int                         sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                mode = fsa_pkg::MODE_MOV;
            end else if (sel < 95) begin
                mode = fsa_pkg::MODE_W'($urandom_range(fsa_pkg::MODE_ASR, fsa_pkg::MODE_ADD));
            end else begin
                mode = fsa_pkg::MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
            end
            imm = (mode == fsa_pkg::MODE_MOV) ? pick_operand() : $urandom;
            send_request(mode, fsa_pkg::IDX_W'($urandom), fsa_pkg::IDX_W'($urandom),
                         fsa_pkg::IDX_W'($urandom), imm);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 200;
        test_random(40);
    endtask

    initial begin
        for (int i = 0; i < fsa_pkg::NUM_REGS; i++) begin
            model_regs[i] = '0;
        end
        model_flags = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 15;
        rx_stall_pct = 81;
        test_reset_state();
        test_mov_extremes();
        test_add_sub_flags();
        test_logical_ops();
        test_shift_edges();
        test_unused_modes();
        test_random(300);

        tx_idle_pct = 81;
        rx_stall_pct = 15;
        test_random(300);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        test_random(160);
        test_backpressure();
        test_random(200);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("flag_setting_alu_with_register_file_unit: match");
        end else begin
            $display("flag_setting_alu_with_register_file_unit: mismatch");
        end
        $finish;
    end

endmodule

### flag_setting_alu_with_register_file_unit.f
rtl/fsa_pkg.sv
rtl/fsa_regfile.sv
rtl/fsa_alu.sv
rtl/flag_setting_alu_with_register_file_unit.sv
rtl/fsa_checker.sv
tb/flag_setting_alu_with_register_file_unit_tb.sv
